FILE: hdl/plob_pkg.sv
// Shared types and constants for the price level order book.
// Used by plob_cell, plob_side and price_level_order_book; no dependencies.
package plob_pkg;

  localparam int unsigned LEVELS    = 64;
  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned QTY_W     = 32;
  localparam int unsigned CNT_W     = $clog2(LEVELS + 1);
  localparam int unsigned LVL_OUT_W = 7;
  localparam int unsigned MID_W     = PRICE_W + 1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_ADD   = 2'd2
  } plob_cmd_e;

  localparam logic SIDE_BID    = 1'b0;
  localparam logic SIDE_ASK    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One price level as held by a cell.
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } plob_entry_t;

  // Action broadcast from a side controller to every cell of its row.
  typedef struct packed {
    logic             clear;
    logic             insert;
    logic             remove;
    logic             modify;
    logic             add;
    logic [QTY_W-1:0] qty;
  } plob_act_t;

  // Command handed from the top level to one side.
  typedef struct packed {
    logic               en;
    logic               clear;
    logic               set;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } plob_op_t;

endpackage

FILE: hdl/plob_cell.sv
// One cell of a sorted price level row: holds a single level and shifts
// toward either neighbor on insert or remove. Depends on plob_pkg.
module plob_cell import plob_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ask_i,
  input  logic [PRICE_W-1:0] price_i,
  input  plob_act_t          act_i,
  input  logic               prev_gt_i,
  input  plob_entry_t        prev_entry_i,
  input  plob_entry_t        next_entry_i,
  output logic               gt_o,
  output logic               hit_o,
  output plob_entry_t        entry_o
);

  logic               valid_q, valid_d;
  logic [PRICE_W-1:0] price_q, price_d;
  logic [QTY_W-1:0]   qty_q, qty_d;
  logic               eq;
  logic               beats;
  logic               ins_here;
  logic [QTY_W:0]     sum;
  logic [QTY_W-1:0]   new_qty;

  // The row is sorted best first, so the cells that beat the key form a
  // prefix and the first cell outside it is where the key belongs.
  assign eq       = valid_q && (price_q == price_i);
  assign beats    = ask_i ? (price_q < price_i) : (price_q > price_i);
  assign gt_o     = valid_q && beats;
  assign ins_here = prev_gt_i && !gt_o;
  assign hit_o    = ins_here && eq;

  assign sum     = {1'b0, qty_q} + {1'b0, act_i.qty};
  assign new_qty = act_i.add ? (sum[QTY_W] ? {QTY_W{1'b1}} : sum[QTY_W-1:0]) : act_i.qty;

  always_comb begin
    valid_d = valid_q;
    price_d = price_q;
    qty_d   = qty_q;
    if (act_i.clear) begin
      valid_d = 1'b0;
    end else if (act_i.insert) begin
      if (ins_here) begin
        valid_d = 1'b1;
        price_d = price_i;
        qty_d   = act_i.qty;
      end else if (!prev_gt_i) begin
        valid_d = prev_entry_i.valid;
        price_d = prev_entry_i.price;
        qty_d   = prev_entry_i.qty;
      end
    end else if (act_i.remove) begin
      // The removed level and every cell behind it take the next entry.
      if (!gt_o) begin
        valid_d = next_entry_i.valid;
        price_d = next_entry_i.price;
        qty_d   = next_entry_i.qty;
      end
    end else if (act_i.modify && hit_o) begin
      qty_d = new_qty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
  end

  assign entry_o = {valid_q, price_q, qty_q};

endmodule

FILE: hdl/plob_side.sv
// One side of the book: a row of plob_cell kept sorted best first, the
// level count and the set/add/remove decision. Depends on plob_pkg, plob_cell.
module plob_side import plob_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ask_i,
  input  plob_op_t         op_i,
  output logic             full_o,
  output plob_entry_t      head_o,
  output logic [CNT_W-1:0] count_o
);

  logic [LEVELS-1:0] gt_vec;
  logic [LEVELS-1:0] hit_vec;
  plob_entry_t       entry_arr [LEVELS];
  plob_act_t         act;
  logic              hit;
  logic              qty_zero;
  logic              create;
  logic              is_full;
  logic [CNT_W-1:0]  count_q, count_d;

  assign hit      = |hit_vec;
  assign qty_zero = (op_i.qty == '0);
  assign is_full  = (count_q == CNT_W'(LEVELS));
  assign create   = op_i.en && !op_i.clear && !hit && !qty_zero;

  always_comb begin
    act.clear  = op_i.en && op_i.clear;
    act.insert = create && !is_full;
    act.remove = op_i.en && !op_i.clear && op_i.set && hit && qty_zero;
    act.modify = op_i.en && !op_i.clear && hit && !(op_i.set && qty_zero);
    act.add    = !op_i.set;
    act.qty    = op_i.qty;
  end

  assign full_o = create && is_full;

  always_comb begin
    count_d = count_q;
    if (act.clear) begin
      count_d = '0;
    end else if (act.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (act.remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic        prev_gt;
    plob_entry_t prev_entry;
    plob_entry_t next_entry;

    if (i == 0) begin : g_first
      assign prev_gt    = 1'b1;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_gt    = gt_vec[i-1];
      assign prev_entry = entry_arr[i-1];
    end

    if (i == LEVELS - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entry_arr[i+1];
    end

    plob_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ask_i        (ask_i),
      .price_i      (op_i.price),
      .act_i        (act),
      .prev_gt_i    (prev_gt),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .gt_o         (gt_vec[i]),
      .hit_o        (hit_vec[i]),
      .entry_o      (entry_arr[i])
    );
  end

  assign head_o  = entry_arr[0];
  assign count_o = count_q;

endmodule

FILE: hdl/price_level_order_book.sv
// Top level of the price level order book: input register, command sequencer,
// bid and ask rows (plob_side) and output register. Depends on plob_pkg, plob_side.
//
//  channel  | direction | tdata                               | tuser
//  s_axis   | in        | price, quantity                     | cmd, side
//  m_axis   | out       | presence, best prices, mid, counts  | status
//
// An item passes through the accept state, an update state in which every cell
// of the addressed row compares and shifts at once, and a response state that
// loads the output register; the next item is accepted after that.
// Reset clears the valid bits and level counts at once, with no sweep.
// A stalled output holds its result; one further item can be taken and
// waits, fully updated, until the output register frees up.
module price_level_order_book import plob_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,  // price [31:0], quantity [63:32]
  input  logic [2:0]    s_axis_tuser,  // cmd [1:0], side [2]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // bid_present [0], best_bid [32:1], ask_present [33], best_ask [65:34],
  // mid_half_ticks [98:66], bid_levels [105:99], ask_levels [112:106], zero above
  output logic [119:0]  m_axis_tdata,
  output logic [0:0]    m_axis_tuser   // status [0]
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_RESP
  } state_e;

  state_e             state_q;
  logic [1:0]         cmd_q;
  logic               side_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  logic               status_q;
  logic               out_valid_q;
  logic [119:0]       out_data_q;
  logic               out_status_q;

  plob_op_t         bid_op, ask_op;
  logic             bid_full, ask_full;
  plob_entry_t      bid_head, ask_head;
  logic [CNT_W-1:0] bid_count, ask_count;

  logic                   upd;
  logic                   level_cmd;
  logic                   in_xfer;
  logic                   out_free;
  logic [PRICE_W-1:0]     best_bid, best_ask;
  logic [MID_W-1:0]       mid;
  logic [CNT_W+LVL_OUT_W-1:0] bid_cnt_ext, ask_cnt_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign upd           = (state_q == S_UPD);
  assign level_cmd     = (cmd_q == CMD_SET) || (cmd_q == CMD_ADD);

  always_comb begin
    bid_op.en    = upd && ((cmd_q == CMD_CLEAR) || (level_cmd && side_q == SIDE_BID));
    bid_op.clear = (cmd_q == CMD_CLEAR);
    bid_op.set   = (cmd_q == CMD_SET);
    bid_op.price = price_q;
    bid_op.qty   = qty_q;
    ask_op.en    = upd && ((cmd_q == CMD_CLEAR) || (level_cmd && side_q == SIDE_ASK));
    ask_op.clear = (cmd_q == CMD_CLEAR);
    ask_op.set   = (cmd_q == CMD_SET);
    ask_op.price = price_q;
    ask_op.qty   = qty_q;
  end

  plob_side u_bid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ask_i   (SIDE_BID),
    .op_i    (bid_op),
    .full_o  (bid_full),
    .head_o  (bid_head),
    .count_o (bid_count)
  );

  plob_side u_ask (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ask_i   (SIDE_ASK),
    .op_i    (ask_op),
    .full_o  (ask_full),
    .head_o  (ask_head),
    .count_o (ask_count)
  );

  // Each row is sorted best first, so its head cell holds the best price.
  assign best_bid    = bid_head.valid ? bid_head.price : '0;
  assign best_ask    = ask_head.valid ? ask_head.price : '0;
  assign mid         = (bid_head.valid && ask_head.valid) ?
                       ({1'b0, best_bid} + {1'b0, best_ask}) : '0;
  assign bid_cnt_ext = {{LVL_OUT_W{1'b0}}, bid_count};
  assign ask_cnt_ext = {{LVL_OUT_W{1'b0}}, ask_count};

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      price_q <= s_axis_tdata[31:0];
      qty_q   <= s_axis_tdata[63:32];
      cmd_q   <= s_axis_tuser[1:0];
      side_q  <= s_axis_tuser[2];
    end
    if (upd) begin
      status_q <= bid_full || ask_full;
    end
    if (state_q == S_RESP && out_free) begin
      out_status_q <= status_q;
      out_data_q   <= {7'd0, ask_cnt_ext[LVL_OUT_W-1:0], bid_cnt_ext[LVL_OUT_W-1:0],
                       mid, best_ask, ask_head.valid, best_bid, bid_head.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new result loaded in the same cycle as a transfer keeps the output valid.
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

FILE: test/plob_checker.sv
`timescale 1ns / 100ps
// Checker for the price level order book: watches both stream channels, keeps
// its own copy of the bid and ask level tables and compares every quote.
// Depends on plob_pkg.
module plob_checker import plob_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  input  logic          s_axis_tready_i,
  input  logic [63:0]   s_axis_tdata_i,   // price [31:0], quantity [63:32]
  input  logic [2:0]    s_axis_tuser_i,   // cmd [1:0], side [2]
  input  logic          m_axis_tvalid_i,
  input  logic          m_axis_tready_i,
  input  logic [119:0]  m_axis_tdata_i,
  input  logic [0:0]    m_axis_tuser_i,   // status [0]
  output int unsigned   mismatches_o,
  output int unsigned   pending_o
);

  typedef struct packed {
    logic                 status;
    logic                 bid_present;
    logic [PRICE_W-1:0]   best_bid;
    logic                 ask_present;
    logic [PRICE_W-1:0]   best_ask;
    logic [MID_W-1:0]     mid;
    logic [LVL_OUT_W-1:0] bid_levels;
    logic [LVL_OUT_W-1:0] ask_levels;
  } quote_t;

  // Level tables indexed by side, then by entry.
  logic               lvl_valid [2][LEVELS];
  logic [PRICE_W-1:0] lvl_price [2][LEVELS];
  logic [QTY_W-1:0]   lvl_qty   [2][LEVELS];

  quote_t      expected_quotes[$];
  int unsigned mismatches  = 0;
  int unsigned outstanding = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = outstanding;

  task automatic update_level(input logic [1:0] cmd, input logic side,
                              input logic [PRICE_W-1:0] price,
                              input logic [QTY_W-1:0] qty, output logic status);
    int           hit;
    int           free_idx;
    logic [QTY_W:0] sum;
    hit      = -1;
    free_idx = -1;
    status   = STATUS_OK;
    for (int i = 0; i < LEVELS; i++) begin
      if (lvl_valid[side][i]) begin
        if (hit < 0 && lvl_price[side][i] == price) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      if (cmd == CMD_SET) begin
        if (qty == '0) lvl_valid[side][hit] = 1'b0;
        else lvl_qty[side][hit] = qty;
      end else begin
        sum = {1'b0, lvl_qty[side][hit]} + {1'b0, qty};
        lvl_qty[side][hit] = sum[QTY_W] ? '1 : sum[QTY_W-1:0];
      end
    end else if (qty != '0) begin
      if (free_idx < 0) begin
        status = STATUS_FULL;
      end else begin
        lvl_valid[side][free_idx] = 1'b1;
        lvl_price[side][free_idx] = price;
        lvl_qty[side][free_idx]   = qty;
      end
    end
  endtask

  task automatic predict_quote(input logic [1:0] cmd, input logic side,
                               input logic [PRICE_W-1:0] price,
                               input logic [QTY_W-1:0] qty, output quote_t q);
    logic status;
    int   nbid;
    int   nask;
    q      = '0;
    status = STATUS_OK;
    nbid   = 0;
    nask   = 0;
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < LEVELS; i++) begin
          lvl_valid[SIDE_BID][i] = 1'b0;
          lvl_valid[SIDE_ASK][i] = 1'b0;
        end
      end
      CMD_SET, CMD_ADD: update_level(cmd, side, price, qty, status);
      default: ;
    endcase
    for (int i = 0; i < LEVELS; i++) begin
      if (lvl_valid[SIDE_BID][i]) begin
        if (nbid == 0 || lvl_price[SIDE_BID][i] > q.best_bid)
          q.best_bid = lvl_price[SIDE_BID][i];
        nbid++;
      end
      if (lvl_valid[SIDE_ASK][i]) begin
        if (nask == 0 || lvl_price[SIDE_ASK][i] < q.best_ask)
          q.best_ask = lvl_price[SIDE_ASK][i];
        nask++;
      end
    end
    q.status      = status;
    q.bid_present = (nbid != 0);
    q.ask_present = (nask != 0);
    if (nbid != 0 && nask != 0) q.mid = {1'b0, q.best_bid} + {1'b0, q.best_ask};
    q.bid_levels  = nbid[LVL_OUT_W-1:0];
    q.ask_levels  = nask[LVL_OUT_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : book_tracking
    quote_t want;
    quote_t got;
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        lvl_valid[SIDE_BID][i] = 1'b0;
        lvl_valid[SIDE_ASK][i] = 1'b0;
      end
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_quote(s_axis_tuser_i[1:0], s_axis_tuser_i[2], s_axis_tdata_i[31:0],
                      s_axis_tdata_i[63:32], want);
        expected_quotes.push_back(want);
        outstanding++;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status      = m_axis_tuser_i[0];
        got.bid_present = m_axis_tdata_i[0];
        got.best_bid    = m_axis_tdata_i[32:1];
        got.ask_present = m_axis_tdata_i[33];
        got.best_ask    = m_axis_tdata_i[65:34];
        got.mid         = m_axis_tdata_i[98:66];
        got.bid_levels  = m_axis_tdata_i[105:99];
        got.ask_levels  = m_axis_tdata_i[112:106];
        if (expected_quotes.size() == 0) begin
          mismatches++;
          $display("%0t ns: quote transfer with nothing expected, got 0x%0h",
                   $time, got);
        end else begin
          want = expected_quotes.pop_front();
          outstanding--;
          check_field("status", want.status, got.status);
          check_field("bid_present", want.bid_present, got.bid_present);
          check_field("best_bid", want.best_bid, got.best_bid);
          check_field("ask_present", want.ask_present, got.ask_present);
          check_field("best_ask", want.best_ask, got.best_ask);
          check_field("mid_half_ticks", want.mid, got.mid);
          check_field("bid_levels", want.bid_levels, got.bid_levels);
          check_field("ask_levels", want.ask_levels, got.ask_levels);
          check_field("tdata padding", '0, m_axis_tdata_i[119:113]);
        end
      end
    end
  end

endmodule

FILE: test/tb_price_level_order_book.sv
`timescale 1ns / 100ps
// Testbench top for the price level order book: drives directed and random
// book updates with random pacing on both channels; plob_checker does the checking.
// Depends on plob_pkg, price_level_order_book and plob_checker.
module tb_price_level_order_book;
  import plob_pkg::*;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ORDERS = 1050;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned DRAIN_CYCLES  = 12;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic [63:0]   s_axis_tdata  = '0;
  logic [2:0]    s_axis_tuser  = '0;
  logic          m_axis_tready = 1'b0;
  logic          s_axis_tready;
  logic          m_axis_tvalid;
  logic [119:0]  m_axis_tdata;
  logic [0:0]    m_axis_tuser;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned orders_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  logic        no_gaps     = 1'b0;

  always #5 clk_i = ~clk_i;

  price_level_order_book DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  plob_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The quote sink holds each ready level for a random stretch, mostly short.
  always @(negedge clk_i) begin : sink_pacing
    int unsigned r;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_axis_tready <= 1'b1;
        hold_left     <= $urandom_range(0, 6);
      end else if (r < 70) begin
        m_axis_tready <= 1'b1;
        hold_left     <= $urandom_range(20, 80);
      end else if (r < 94) begin
        m_axis_tready <= 1'b0;
        hold_left     <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        hold_left     <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_qty();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 20) return '1;
    if (r < 60) return $urandom_range(1, 100);
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_order(input logic [1:0] cmd, input logic side,
                            input logic [31:0] price, input logic [31:0] qty);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {qty, price};
    s_axis_tuser  <= {side, cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    orders_sent++;
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned n;
    int unsigned span;
    int unsigned stop_at;
    logic        side;
    logic [1:0]  cmd;
    logic [31:0] base;
    logic [31:0] price;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed: price and quantity extremes, saturation, removals, zero adds.
    send_order(CMD_CLEAR, SIDE_BID, '0, '0);
    send_order(CMD_SET, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_SET, SIDE_ASK, 32'h0000_0000, 32'h0000_0001);
    send_order(CMD_SET, SIDE_ASK, 32'hFFFF_FFFF, 32'h0000_0005);
    send_order(CMD_SET, SIDE_BID, 32'hFFFF_FFFE, 32'h0000_0001);
    send_order(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 32'h0000_0001);
    send_order(CMD_ADD, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_ADD, SIDE_ASK, 32'h1234_5678, 32'h0000_0000);
    send_order(CMD_ADD, SIDE_ASK, 32'h8000_0000, 32'h0000_0007);
    send_order(CMD_SET, SIDE_BID, 32'hFFFF_FFFF, 32'h55AA_55AA);
    send_order(CMD_SET, SIDE_ASK, 32'h0000_0000, 32'h0000_0000);
    send_order(CMD_SET, SIDE_ASK, 32'h0BAD_F00D, 32'h0000_0000);
    send_order(CMD_SET, SIDE_BID, 32'hFFFF_FFFF, 32'h0000_0000);
    send_order(CMD_SET, SIDE_BID, 32'h0000_0000, 32'h8000_0000);
    send_order(CMD_UNUSED, SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_CLEAR, SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_SET, SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_SET, SIDE_BID, 32'hFFFF_FFFF, 32'h0000_0001);
    send_order(CMD_ADD, SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_SET, SIDE_BID, 32'hAAAA_AAAA, 32'h5555_5555);
    send_order(CMD_SET, SIDE_ASK, 32'h5555_5555, 32'hAAAA_AAAA);
    send_order(CMD_UNUSED, SIDE_BID, 32'h0000_0000, 32'h0000_0000);
    send_order(CMD_CLEAR, SIDE_BID, '0, '0);

    stop_at = orders_sent + RANDOM_ORDERS;
    while (orders_sent < stop_at) begin
      kind    = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (kind < 60) begin
        // Snapshot followed by incremental updates around a mid price.
        base = $urandom_range(32'h0000_1000, 32'hFFFF_0000);
        case ($urandom_range(0, 2))
          0:       span = 8;
          1:       span = 40;
          default: span = 120;
        endcase
        n = $urandom_range(8, 90);
        send_order(CMD_CLEAR, $urandom_range(0, 1), $urandom, $urandom);
        repeat (n) begin
          side  = $urandom_range(0, 1);
          price = (side == SIDE_BID) ? base - $urandom_range(1, span)
                                     : base + $urandom_range(0, span - 1);
          cmd   = ($urandom_range(0, 99) < 55) ? CMD_SET : CMD_ADD;
          send_order(cmd, side, price, pick_qty());
        end
      end else if (kind < 75) begin
        // Push one side past its capacity, then free and refill an entry.
        side = $urandom_range(0, 1);
        base = $urandom;
        send_order(CMD_CLEAR, side, base, '0);
        for (int i = 0; i < LEVELS + 4; i++)
          send_order(CMD_SET, side, base + i, $urandom_range(1, 1000));
        send_order(CMD_SET, side, base + 5, '0);
        send_order(CMD_ADD, side, base + 200, $urandom_range(1, 50));
        send_order(CMD_ADD, side, base + 201, 32'hFFFF_FFFF);
        send_order(CMD_ADD, side, base + 202, '0);
        send_order(CMD_ADD, side, base + 200, 32'hFFFF_FFFF);
        send_order(CMD_SET, !side, base, 32'h0000_0001);
        send_order(CMD_SET, side, base + 3, '0);
        send_order(CMD_SET, side, base + 3, '0);
      end else begin
        // Unstructured traffic, including stray clears and the unused command.
        n = $urandom_range(4, 24);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) cmd = CMD_CLEAR;
          else if ($urandom_range(0, 19) == 0) cmd = CMD_UNUSED;
          else if ($urandom_range(0, 1) == 0) cmd = CMD_SET;
          else cmd = CMD_ADD;
          price = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15);
          send_order(cmd, $urandom_range(0, 1), price,
                     ($urandom_range(0, 1) == 0) ? $urandom : pick_qty());
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
